// ===== sv/bidsig_pkg.sv =====
// shared types and codes for the book imbalance decay signal
package bidsig_pkg;

  // action codes on the input channel
  localparam logic [1:0] ACT_MARKET = 2'd0;
  localparam logic [1:0] ACT_INTR   = 2'd1;
  localparam logic [1:0] ACT_RESUME = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // request kinds held in the queue
  localparam logic [1:0] KIND_MARKET = 2'd0;
  localparam logic [1:0] KIND_INTR   = 2'd1;
  localparam logic [1:0] KIND_RESUME = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int OUT_W  = 19;

  localparam logic [15:0] DECAY_RESET = 16'd39322;

  typedef struct packed {
    logic [1:0]         kind;
    logic               from_leader;
    logic               from_follower;
    logic               books_ready;
    logic signed [31:0] bid_price;
    logic signed [31:0] ask_price;
    logic [23:0]        bid_size;
    logic [23:0]        ask_size;
  } item_t;

endpackage

// ===== sv/bidsig_front.sv =====
// front part: takes requests, drops unused actions, classifies the rest
module bidsig_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           action,
  input  logic                 from_leader,
  input  logic                 from_follower,
  input  logic                 books_ready,
  input  logic signed [31:0]   bid_price,
  input  logic signed [31:0]   ask_price,
  input  logic [23:0]          bid_size,
  input  logic [23:0]          ask_size,
  input  logic                 q_full,
  output logic                 push,
  output bidsig_pkg::item_t    push_item
);

  logic [1:0] kind;
  logic       keep;

  always_comb begin
    kind = bidsig_pkg::KIND_MARKET;
    keep = 1'b1;
    case (action)
      bidsig_pkg::ACT_MARKET: kind = bidsig_pkg::KIND_MARKET;
      bidsig_pkg::ACT_INTR:   kind = bidsig_pkg::KIND_INTR;
      bidsig_pkg::ACT_RESUME: kind = bidsig_pkg::KIND_RESUME;
      default:                keep = 1'b0;
    endcase
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full && keep;

  always_comb begin
    push_item.kind          = kind;
    push_item.from_leader   = from_leader;
    push_item.from_follower = from_follower;
    push_item.books_ready   = books_ready;
    push_item.bid_price     = bid_price;
    push_item.ask_price     = ask_price;
    push_item.bid_size      = bid_size;
    push_item.ask_size      = ask_size;
  end

endmodule

// ===== sv/bidsig_fifo.sv =====
// short request queue between front and back
module bidsig_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bidsig_pkg::item_t push_item,
  input  logic              pop,
  output bidsig_pkg::item_t head,
  output logic              full,
  output logic              empty
);

  bidsig_pkg::item_t                 mem [bidsig_pkg::QDEPTH];
  logic [bidsig_pkg::QPTR_W-1:0]     wr_ptr;
  logic [bidsig_pkg::QPTR_W-1:0]     rd_ptr;
  logic [bidsig_pkg::QPTR_W:0]       count;

  assign full  = (count == (bidsig_pkg::QPTR_W+1)'(bidsig_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/bidsig_div.sv =====
// serial restoring divider, quotient rounded half away from zero on magnitudes
module bidsig_div #(
  parameter int NW = 40,
  parameter int DW = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW:0]   quot
);

  localparam int CW = $clog2(NW + 2);

  logic [NW:0]   dvd;
  logic [DW-1:0] rem;
  logic [DW-1:0] dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem, dvd[NW]};
  assign ge     = (rem_sh >= {1'b0, dsr});
  assign quot   = dvd;

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {1'b0, num} + (NW+1)'(den >> 1);
      rem <= '0;
      dsr <= den;
    end else if (busy) begin
      dvd <= {dvd[NW-1:0], ge};
      rem <= ge ? DW'(rem_sh - {1'b0, dsr}) : rem_sh[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW + 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/bidsig_back.sv =====
// back part: sequencer that runs the imbalance, average and correction
module bidsig_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [15:0]                        decay_cfg,
  input  logic                               q_empty,
  input  bidsig_pkg::item_t                  head,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [bidsig_pkg::OUT_W-1:0] signal_value
);

  localparam int F   = FRAC_BITS;
  localparam int AW  = F + 3;
  localparam int MW  = F + 3;
  localparam int PW  = 2 * MW;
  localparam int DW  = (F + 1 > 25) ? F + 1 : 25;
  localparam int NW  = F + ((F + 1 > 24) ? F + 1 : 24);
  localparam logic [F:0]  ONE  = (F+1)'(1) << F;
  localparam logic [PW:0] HALF = (PW+1)'(1) << (F - 1);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_LEAD     = 4'd1;
  localparam logic [3:0] ST_MUL_DP   = 4'd2;
  localparam logic [3:0] ST_DP_RND   = 4'd3;
  localparam logic [3:0] ST_IMB      = 4'd4;
  localparam logic [3:0] ST_IMB_WAIT = 4'd5;
  localparam logic [3:0] ST_AVG1     = 4'd6;
  localparam logic [3:0] ST_AVG2     = 4'd7;
  localparam logic [3:0] ST_AVG_R1   = 4'd8;
  localparam logic [3:0] ST_AVG_SUM  = 4'd9;
  localparam logic [3:0] ST_COR      = 4'd10;
  localparam logic [3:0] ST_COR_WAIT = 4'd11;
  localparam logic [3:0] ST_STORE    = 4'd12;
  localparam logic [3:0] ST_FINISH   = 4'd13;
  localparam logic [3:0] ST_EMIT     = 4'd14;

  function automatic logic signed [AW-1:0] rnd(input logic signed [PW:0] x);
    logic [PW:0] mag;
    logic [PW:0] r;
    logic [PW:0] res;
    mag = x[PW] ? (PW+1)'(-x) : x;
    r   = (mag + HALF) >> F;
    res = x[PW] ? (PW+1)'(-r) : r;
    return res[AW-1:0];
  endfunction

  logic [3:0]               state;
  bidsig_pkg::item_t        itm;
  logic                     ready_flag;
  logic                     intr_flag;
  logic signed [31:0]       ldr_bid;
  logic signed [31:0]       ldr_ask;
  logic signed [31:0]       fol_bid;
  logic signed [31:0]       fol_ask;
  logic [1:0]               run_cnt;
  logic [F:0]               dpow;
  logic signed [AW-1:0]     avg;
  logic signed [AW-1:0]     imb;
  logic signed [AW-1:0]     sig;
  logic signed [PW-1:0]     prod1;
  logic signed [PW-1:0]     prod2;
  logic                     neg;
  logic [bidsig_pkg::OUT_W-1:0] emit_val;

  logic [16+F-1:0]          d_wide;
  logic [F:0]               dval;
  logic [F:0]               one_m_d;
  logic signed [MW-1:0]     mul_a;
  logic signed [MW-1:0]     mul_b;
  logic signed [PW-1:0]     prod;
  logic signed [32:0]       spread;
  logic                     quote_same;
  logic [24:0]              size_sum;
  logic [23:0]              size_diff;
  logic [AW-1:0]            avg_mag;
  logic signed [AW-1:0]     avg_new;

  logic                     div_start;
  logic [NW-1:0]            div_num;
  logic [DW-1:0]            div_den;
  logic                     div_done;
  logic [NW:0]              div_quot;
  logic [F:0]               cor_mag;
  logic signed [AW-1:0]     cor;

  logic signed [31:0]       fb_new;
  logic signed [31:0]       fa_new;
  logic signed [AW-1:0]     fin_sig;
  logic signed [63:0]       fin_ext;

  assign d_wide  = {decay_cfg, {F{1'b0}}} >> 16;
  assign dval    = d_wide[F:0];
  assign one_m_d = ONE - dval;

  assign spread     = 33'(itm.ask_price) - 33'(itm.bid_price);
  assign quote_same = (itm.bid_price == ldr_bid) && (itm.ask_price == ldr_ask);
  assign size_sum   = {1'b0, itm.bid_size} + {1'b0, itm.ask_size};
  assign size_diff  = (itm.bid_size >= itm.ask_size) ? itm.bid_size - itm.ask_size
                                                      : itm.ask_size - itm.bid_size;
  assign avg_mag    = avg[AW-1] ? AW'(-avg) : avg;
  assign avg_new    = rnd((PW+1)'(prod1) + (PW+1)'(prod2));

  // shared multiplier, one product per cycle
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MUL_DP: begin
        mul_a = $signed({2'b00, dpow});
        mul_b = $signed({2'b00, dval});
      end
      ST_AVG1: begin
        mul_a = $signed({2'b00, one_m_d});
        mul_b = imb;
      end
      ST_AVG2: begin
        mul_a = avg;
        mul_b = $signed({2'b00, dval});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state == ST_IMB && size_sum != '0) begin
      div_start = 1'b1;
      div_num   = NW'({size_diff, {F{1'b0}}});
      div_den   = DW'(size_sum);
    end else if (state == ST_COR && dpow != ONE) begin
      div_start = 1'b1;
      div_num   = NW'({avg_mag, {F{1'b0}}});
      div_den   = DW'(ONE - dpow);
    end
  end

  bidsig_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign cor_mag = (div_quot > (NW+1)'(ONE)) ? ONE : div_quot[F:0];
  assign cor     = neg ? -$signed({2'b00, cor_mag}) : $signed({2'b00, cor_mag});

  assign fb_new  = itm.from_follower ? itm.bid_price : fol_bid;
  assign fa_new  = itm.from_follower ? itm.ask_price : fol_ask;
  assign fin_sig = (intr_flag || fb_new != ldr_bid || fa_new != ldr_ask) ? '0 : sig;
  assign fin_ext = 64'(fin_sig);

  assign pop = (state == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (pop) begin
      itm <= head;
    end
    case (state)
      ST_MUL_DP: prod1 <= prod;
      ST_AVG1:   prod1 <= prod;
      ST_AVG2:   prod2 <= prod;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ready_flag <= 1'b0;
      intr_flag  <= 1'b0;
      ldr_bid    <= '0;
      ldr_ask    <= '0;
      fol_bid    <= '0;
      fol_ask    <= '0;
      run_cnt    <= '0;
      dpow       <= ONE;
      avg        <= '0;
      imb        <= '0;
      sig        <= '0;
      neg        <= 1'b0;
      emit_val   <= '0;
      out_valid  <= 1'b0;
    end else begin
      // the emit state loads the result register itself
      if (out_valid && !out_stall && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            case (head.kind)
              bidsig_pkg::KIND_INTR: begin
                intr_flag <= 1'b1;
                sig       <= '0;
                avg       <= '0;
                emit_val  <= '0;
                state     <= ST_EMIT;
              end
              bidsig_pkg::KIND_RESUME: begin
                intr_flag <= 1'b0;
              end
              default: begin
                if (!ready_flag) begin
                  if (head.books_ready) begin
                    ready_flag <= 1'b1;
                    sig        <= '0;
                    emit_val   <= '0;
                    state      <= ST_EMIT;
                  end
                end else if (head.from_leader) begin
                  state <= ST_LEAD;
                end else begin
                  state <= ST_FINISH;
                end
              end
            endcase
          end
        end
        ST_LEAD: begin
          if (spread > 33'sd1) begin
            run_cnt <= '0;
            dpow    <= ONE;
            sig     <= '0;
            avg     <= '0;
            state   <= ST_STORE;
          end else if (!quote_same) begin
            run_cnt <= 2'd1;
            dpow    <= dval;
            state   <= ST_IMB;
          end else begin
            if (run_cnt != 2'd2) begin
              run_cnt <= run_cnt + 1'b1;
            end
            state <= ST_MUL_DP;
          end
        end
        ST_MUL_DP: state <= ST_DP_RND;
        ST_DP_RND: begin
          dpow  <= (F+1)'(rnd({prod1[PW-1], prod1}));
          state <= ST_IMB;
        end
        ST_IMB: begin
          neg <= itm.bid_size < itm.ask_size;
          if (size_sum == '0) begin
            imb   <= '0;
            state <= ST_AVG1;
          end else begin
            state <= ST_IMB_WAIT;
          end
        end
        ST_IMB_WAIT: begin
          if (div_done) begin
            imb   <= neg ? -$signed({2'b00, div_quot[F:0]})
                         : $signed({2'b00, div_quot[F:0]});
            state <= ST_AVG1;
          end
        end
        ST_AVG1: state <= (run_cnt == 2'd1) ? ST_AVG_R1 : ST_AVG2;
        ST_AVG2: state <= ST_AVG_SUM;
        ST_AVG_R1: begin
          avg   <= rnd({prod1[PW-1], prod1});
          sig   <= '0;
          state <= ST_STORE;
        end
        ST_AVG_SUM: begin
          avg   <= avg_new;
          state <= ST_COR;
        end
        ST_COR: begin
          neg <= avg[AW-1];
          if (dpow != ONE) begin
            state <= ST_COR_WAIT;
          end else begin
            sig   <= imb - avg;
            state <= ST_STORE;
          end
        end
        ST_COR_WAIT: begin
          if (div_done) begin
            sig   <= imb - cor;
            state <= ST_STORE;
          end
        end
        ST_STORE: begin
          ldr_bid <= itm.bid_price;
          ldr_ask <= itm.ask_price;
          state   <= ST_FINISH;
        end
        ST_FINISH: begin
          fol_bid  <= fb_new;
          fol_ask  <= fa_new;
          sig      <= fin_sig;
          emit_val <= fin_ext[bidsig_pkg::OUT_W-1:0];
          state    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            signal_value <= $signed(emit_val);
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/book_imbalance_decay_signal.sv =====
// top level of the book imbalance decay signal
//
//   channel   direction  handshake            payload
//   in        request    in_valid / in_stall  action, from_leader, from_follower,
//                                             books_ready, bid/ask price, bid/ask size
//   out       result     out_valid/out_stall  signal_value
//   cfg       write      cfg_write            cfg_data (decay factor, Q0.16)
//
// a leader update runs one multiply per cycle and up to two serial divisions:
// two for a continued run, one for a new run, none for a wide spread; a zero
// size sum skips the first division
// other requests need no division; the divider sets the rate
// rst is synchronous; it clears the queue, the flags, the quote history and
// restores the decay factor to its default
// a four-entry queue lets requests be taken while the back part is busy;
// in_stall rises only when the queue is full, out_stall holds the result register
module book_imbalance_decay_signal #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         action,
  input  logic                               from_leader,
  input  logic                               from_follower,
  input  logic                               books_ready,
  input  logic signed [31:0]                 bid_price,
  input  logic signed [31:0]                 ask_price,
  input  logic [23:0]                        bid_size,
  input  logic [23:0]                        ask_size,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [bidsig_pkg::OUT_W-1:0] signal_value,
  // decay factor register
  input  logic                               cfg_write,
  input  logic [15:0]                        cfg_data
);

  // decay factor register, unsigned Q0.16
  logic [15:0]       decay_cfg;

  // front to queue
  logic              push;
  bidsig_pkg::item_t push_item;

  // queue to back
  logic              q_full;
  logic              q_empty;
  logic              pop;
  bidsig_pkg::item_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_cfg <= bidsig_pkg::DECAY_RESET;
    end else if (cfg_write) begin
      decay_cfg <= cfg_data;
    end
  end

  // classify requests, drop the unused action code
  bidsig_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .from_leader   (from_leader),
    .from_follower (from_follower),
    .books_ready   (books_ready),
    .bid_price     (bid_price),
    .ask_price     (ask_price),
    .bid_size      (bid_size),
    .ask_size      (ask_size),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item)
  );

  // decouples request intake from the long arithmetic sequence
  bidsig_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // imbalance, bias-corrected average and output gating
  bidsig_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .decay_cfg    (decay_cfg),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .signal_value (signal_value)
  );

endmodule

// ===== verif/book_imbalance_decay_signal_checker.sv =====
// request/result scoreboard with its own signal predictor for the imbalance block
module book_imbalance_decay_signal_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [1:0]                 action,
  input  logic                       from_leader,
  input  logic                       from_follower,
  input  logic                       books_ready,
  input  logic signed [31:0]         bid_price,
  input  logic signed [31:0]         ask_price,
  input  logic [23:0]                bid_size,
  input  logic [23:0]                ask_size,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [bidsig_pkg::OUT_W-1:0] signal_value,
  input  logic                       cfg_write,
  input  logic [15:0]                cfg_data,
  output int                         fail_count,
  output int                         pending
);

  localparam longint ONE = 64'sd65536;

  logic [15:0]       decay;
  bit                is_ready, is_intr;
  bit [31:0]         lead_bid, lead_ask, foll_bid, foll_ask, run_len;
  longint            dpow, avg_imb, cur_imb, prev_sig;
  bit [bidsig_pkg::OUT_W-1:0] signal_q[$];

  assign pending = signal_q.size();

  function automatic longint round_div(longint num, longint den);
    longint mag;
    mag = num < 0 ? -num : num;
    mag = (mag + den / 2) / den;
    return num < 0 ? -mag : mag;
  endfunction

  // leader quote: end, restart or extend the run, then rebuild the signal
  task automatic leader_step(logic signed [31:0] bp, logic signed [31:0] ap,
                             logic [23:0] bs, logic [23:0] as_);
    longint bid, ask, d, sig, den, corr, tot;
    bid = bp;
    ask = ap;
    d = decay;
    sig = prev_sig;
    if (ask - bid > 1) begin
      cur_imb = 0;
      run_len = 0;
      dpow = ONE;
    end else if (bp != lead_bid || ap != lead_ask) begin
      run_len = 1;
      dpow = d;
    end else begin
      if (run_len != 32'hFFFF_FFFF) run_len++;
      dpow = round_div(dpow * d, ONE);
    end
    if (run_len == 0) begin
      sig = 0;
      avg_imb = 0;
      dpow = ONE;
    end else begin
      tot = longint'(bs) + longint'(as_);
      cur_imb = tot == 0 ? 0 : round_div((longint'(bs) - longint'(as_)) * ONE, tot);
      if (run_len == 1) begin
        avg_imb = round_div((ONE - d) * cur_imb, ONE);
        sig = 0;
      end else begin
        den = ONE - dpow;
        avg_imb = round_div(avg_imb * d + (ONE - d) * cur_imb, ONE);
        if (den > 0) begin
          corr = round_div(avg_imb * ONE, den);
          if (corr > ONE) corr = ONE;
          if (corr < -ONE) corr = -ONE;
        end else begin
          corr = avg_imb;
        end
        sig = cur_imb - corr;
      end
    end
    lead_bid = bp;
    lead_ask = ap;
    prev_sig = sig;
  endtask

  task automatic predict_request();
    if (action == bidsig_pkg::ACT_INTR) begin
      is_intr = 1;
      prev_sig = 0;
      cur_imb = 0;
      avg_imb = 0;
      signal_q.push_back('0);
    end else if (action == bidsig_pkg::ACT_RESUME) begin
      is_intr = 0;
    end else if (action == bidsig_pkg::ACT_MARKET) begin
      if (!is_ready) begin
        if (books_ready) begin
          is_ready = 1;
          prev_sig = 0;
          signal_q.push_back('0);
        end
      end else begin
        if (from_leader) leader_step(bid_price, ask_price, bid_size, ask_size);
        if (from_follower) begin
          foll_bid = bid_price;
          foll_ask = ask_price;
        end
        if (is_intr) prev_sig = 0;
        if (foll_bid != lead_bid || foll_ask != lead_ask) prev_sig = 0;
        signal_q.push_back(prev_sig[bidsig_pkg::OUT_W-1:0]);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      decay = bidsig_pkg::DECAY_RESET;
      is_ready = 0;
      is_intr = 0;
      lead_bid = 0;
      lead_ask = 0;
      foll_bid = 0;
      foll_ask = 0;
      run_len = 0;
      dpow = ONE;
      avg_imb = 0;
      cur_imb = 0;
      prev_sig = 0;
      signal_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (signal_q.size() == 0) begin
          $error("unexpected result signal_value=%0d", signal_value);
          fail_count++;
        end else begin
          if (signal_q[0] != signal_value) begin
            $error("signal_value expected %0d actual %0d",
                   $signed(signal_q[0]), signal_value);
            fail_count++;
          end
          void'(signal_q.pop_front());
        end
      end
      if (in_valid && !in_stall) predict_request();
      if (cfg_write) decay = cfg_data;
    end
  end
endmodule

// ===== verif/tb_book_imbalance_decay_signal.sv =====
// stimulus and verdict for the book imbalance decay signal
module tb_book_imbalance_decay_signal;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] action = bidsig_pkg::ACT_MARKET;
  logic from_leader = 0;
  logic from_follower = 0;
  logic books_ready = 0;
  logic signed [31:0] bid_price = 0;
  logic signed [31:0] ask_price = 0;
  logic [23:0] bid_size = 0;
  logic [23:0] ask_size = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [bidsig_pkg::OUT_W-1:0] signal_value;
  logic cfg_write = 0;
  logic [15:0] cfg_data = 0;
  int fail_count, pending;

  // traffic shaping shared by sender and receiver
  bit calm = 0;          // no idling on either side
  int hold_asks = 0;     // long receiver hold-offs requested
  int hold_seen = 0;

  // current quote that random requests keep revisiting
  logic signed [31:0] q_bid = 100, q_ask = 101;

  always #1 clk = ~clk;

  book_imbalance_decay_signal uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .from_leader(from_leader), .from_follower(from_follower),
    .books_ready(books_ready), .bid_price(bid_price), .ask_price(ask_price),
    .bid_size(bid_size), .ask_size(ask_size),
    .out_valid(out_valid), .out_stall(out_stall), .signal_value(signal_value),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  book_imbalance_decay_signal_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .from_leader(from_leader), .from_follower(from_follower),
    .books_ready(books_ready), .bid_price(bid_price), .ask_price(ask_price),
    .bid_size(bid_size), .ask_size(ask_size),
    .out_valid(out_valid), .out_stall(out_stall), .signal_value(signal_value),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // result side: random stall, plus long hold-offs counted here
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      out_stall <= 1;
      repeat (400) @(negedge clk);
      out_stall <= 0;
    end else if (calm) begin
      out_stall <= 0;
    end else begin
      out_stall <= ($urandom_range(99) < 14);
    end
  end

  // drive one request from a falling edge and hold it until taken
  task automatic send_request(bidsig_pkg::item_t it);
    if (!calm && $urandom_range(99) < 14) begin
      in_valid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1;
    action = it.kind;
    from_leader = it.from_leader;
    from_follower = it.from_follower;
    books_ready = it.books_ready;
    bid_price = it.bid_price;
    ask_price = it.ask_price;
    bid_size = it.bid_size;
    ask_size = it.ask_size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 0;
  endtask

  // block has drained and finished any request that gives no result
  task automatic wait_idle();
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_decay(logic [15:0] val);
    wait_idle();
    cfg_write = 1;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 0;
  endtask

  function automatic bidsig_pkg::item_t market(int ld, int fl, int b, int a,
                                               int bs, int as_);
    bidsig_pkg::item_t it;
    it.kind = bidsig_pkg::ACT_MARKET;
    it.from_leader = 1'(ld);
    it.from_follower = 1'(fl);
    it.books_ready = 1'b1;
    it.bid_price = 32'(b);
    it.ask_price = 32'(a);
    it.bid_size = 24'(bs);
    it.ask_size = 24'(as_);
    return it;
  endfunction

  function automatic logic [23:0] rand_size();
    case ($urandom_range(9))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(1, 20));
      default: return 24'($urandom);
    endcase
  endfunction

  // mostly well-formed quote streams, some events and noise
  function automatic bidsig_pkg::item_t random_request();
    bidsig_pkg::item_t it;
    int r;
    r = $urandom_range(99);
    it = market(1, 1, q_bid, q_ask, rand_size(), rand_size());
    it.books_ready = 1'($urandom_range(1));
    if (r < 8) begin
      it.kind = bidsig_pkg::ACT_INTR;
    end else if (r < 15) begin
      it.kind = bidsig_pkg::ACT_RESUME;
    end else if (r < 17) begin
      it.kind = bidsig_pkg::ACT_UNUSED;
    end else if (r < 25) begin
      // noise prices over the whole range
      it.bid_price = $urandom;
      it.ask_price = $urandom;
      it.from_leader = 1'($urandom_range(1));
      it.from_follower = 1'($urandom_range(1));
    end else begin
      if ($urandom_range(99) < 15) begin
        q_bid = $urandom_range(1, 3) == 1 ? -$signed($urandom_range(0, 500))
                                          : $signed($urandom_range(0, 500));
        q_ask = q_bid + $signed($urandom_range(0, 1));
        if ($urandom_range(9) == 0) q_ask = q_bid - 1;
      end
      it.bid_price = q_bid;
      it.ask_price = q_ask;
      if ($urandom_range(99) < 6) it.ask_price = q_bid + $urandom_range(2, 9);
      r = $urandom_range(9);
      it.from_leader = r != 0;
      it.from_follower = r != 1;
    end
    return it;
  endfunction

  initial begin
    bidsig_pkg::item_t it;
    int sent;
    logic [15:0] decays[5];
    decays = '{bidsig_pkg::DECAY_RESET, 16'd0, 16'hFFFF, 16'd32768, 16'd0};
    decays[4] = 16'($urandom);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // not ready yet: interrupt still answers, market without books is dropped
    it = market(1, 1, 5, 6, 3, 1);
    it.books_ready = 0;
    send_request(it);
    it.kind = bidsig_pkg::ACT_INTR;
    send_request(it);
    it.kind = bidsig_pkg::ACT_RESUME;
    send_request(it);
    it.kind = bidsig_pkg::ACT_UNUSED;
    send_request(it);
    send_request(market(0, 0, 0, 0, 0, 0));    // becomes ready
    // new run, then repeats with both sources, sizes at extremes
    send_request(market(1, 1, 10, 11, 24'hFFFFFF, 0));
    send_request(market(1, 1, 10, 11, 0, 24'hFFFFFF));
    send_request(market(1, 1, 10, 11, 0, 0));
    send_request(market(1, 0, 10, 11, 7, 2));
    send_request(market(0, 1, 10, 11, 1, 9));
    send_request(market(1, 1, 10, 11, 24'hFFFFFF, 24'hFFFFFF));
    // wide spread, extreme prices, crossed quote
    send_request(market(1, 1, 10, 20, 4, 4));
    send_request(market(1, 1, 32'sh7FFFFFFF, 32'sh80000000, 1, 2));
    send_request(market(1, 1, 32'sh80000000, 32'sh7FFFFFFF, 1, 2));
    send_request(market(1, 1, -3, -3, 6, 1));
    send_request(market(1, 1, -3, -3, 6, 1));
    send_request(market(1, 1, -3, -2, 6, 1));   // price change restarts
    // interrupted, still quoting, then resumed
    it.kind = bidsig_pkg::ACT_INTR;
    send_request(it);
    send_request(market(1, 1, -3, -2, 2, 5));
    it.kind = bidsig_pkg::ACT_RESUME;
    send_request(it);
    send_request(market(1, 1, -3, -2, 2, 5));
    send_request(market(1, 1, -3, -2, 2, 5));
    send_request(market(0, 0, -3, -2, 2, 5));

    // sender pauses until everything is back
    while (pending != 0) @(posedge clk);

    foreach (decays[p]) begin
      if (p > 0) write_decay(decays[p]);
      sent = 0;
      while (sent < 210) begin
        calm = (p == 2 && sent >= 40 && sent < 110);
        if (p == 1 && sent == 50) hold_asks++;   // block fills and stalls input
        it = random_request();
        send_request(it);
        if (it.kind != bidsig_pkg::ACT_UNUSED) sent++;
      end
      calm = 0;
    end

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
